### hw/rtl/sfr_pkg.sv
package sfr_pkg;

	// Header byte layout: bits 6..4 carry a fixed pattern, bits 3..0 the length.
	localparam logic [7:0] HDR_FIXED_MASK  = 8'b0111_0000;
	localparam logic [7:0] HDR_FIXED_VALUE = 8'b0010_0000;
	localparam logic [7:0] HDR_LEN_MASK    = 8'b0000_1111;

	// Configuration register indexes.
	localparam logic CFG_MAX_LEN   = 1'b0;
	localparam logic CFG_BUTTON_ID = 1'b1;

	localparam logic [3:0] MAX_LEN_RESET   = 4'd15;
	localparam logic [7:0] BUTTON_ID_RESET = 8'd0;

	// Input action codes.
	localparam logic ACT_BYTE    = 1'b0;
	localparam logic ACT_TIMEOUT = 1'b1;

	typedef enum logic [2:0] {
		KIND_PAYLOAD    = 3'd0,
		KIND_EMPTY_DONE = 3'd1,
		KIND_RESET      = 3'd2,
		KIND_BAD_HEADER = 3'd3,
		KIND_TIMEOUT    = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'b001,
		PH_SERVICE = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] service_id;
		logic [3:0] byte_index;
		logic [7:0] payload_byte;
		logic       last;
		logic [7:0] button_changed;
		logic [7:0] buttons_now;
	} result_t;

	typedef struct packed {
		logic [3:0] max_len;
		logic [7:0] button_id;
	} cfg_t;

endpackage

### hw/rtl/sfr_in_stage.sv
// Input register: holds one accepted transaction until the deframer consumes it.
module sfr_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sfr_pkg::item_t    item,
	input  logic              advance,
	output logic              valid_s1,
	output sfr_pkg::item_t    item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item;
		end
	end

endmodule

### hw/rtl/sfr_deframer.sv
// Frame state and the single-pass decode of one registered item.
module sfr_deframer (
	input  logic              clk,
	input  logic              arst_n,
	input  sfr_pkg::cfg_t     cfg,
	input  logic              step,
	input  sfr_pkg::item_t    item_s1,
	output logic              has_result,
	output sfr_pkg::result_t  result
);

	sfr_pkg::phase_t phase_q, phase_nx;
	logic [3:0] frame_len_q, frame_len_nx;
	logic [3:0] seen_q, seen_nx;
	logic [7:0] service_q, service_nx;
	logic [7:0] pending_q, pending_nx;
	logic [7:0] buttons_q, buttons_nx;

	logic [7:0] b;
	logic [3:0] hdr_len;
	logic       hdr_ok;
	logic [3:0] idx;
	logic       is_button;
	logic       done;

	assign b         = item_s1.rx_byte;
	assign hdr_len   = 4'(b & sfr_pkg::HDR_LEN_MASK);
	assign hdr_ok    = ((b & sfr_pkg::HDR_FIXED_MASK) == sfr_pkg::HDR_FIXED_VALUE)
		&& (hdr_len <= cfg.max_len) && ((^b[6:0]) == b[7]);
	assign idx       = seen_q - 4'd1;
	assign is_button = (service_q == cfg.button_id);

	always_comb begin
		phase_nx     = phase_q;
		frame_len_nx = frame_len_q;
		seen_nx      = seen_q;
		service_nx   = service_q;
		pending_nx   = pending_q;
		buttons_nx   = buttons_q;
		has_result   = 1'b0;
		done         = 1'b0;
		result       = '0;
		result.kind  = sfr_pkg::KIND_PAYLOAD;

		if (item_s1.action == sfr_pkg::ACT_TIMEOUT) begin
			phase_nx = sfr_pkg::PH_HUNT;
			if (phase_q == sfr_pkg::PH_SERVICE || phase_q == sfr_pkg::PH_PAYLOAD) begin
				has_result  = 1'b1;
				result.kind = sfr_pkg::KIND_TIMEOUT;
				if (phase_q == sfr_pkg::PH_PAYLOAD) begin
					result.service_id = service_q;
				end
			end
		end else begin
			case (phase_q)
				sfr_pkg::PH_SERVICE: begin
					service_nx = b;
					seen_nx    = 4'd1;
					if (frame_len_q <= 4'd1) begin
						phase_nx          = sfr_pkg::PH_HUNT;
						has_result        = 1'b1;
						result.kind       = sfr_pkg::KIND_EMPTY_DONE;
						result.service_id = b;
						result.last       = 1'b1;
					end else begin
						phase_nx = sfr_pkg::PH_PAYLOAD;
					end
				end
				sfr_pkg::PH_PAYLOAD: begin
					if (idx == 4'd0 && is_button) begin
						pending_nx = b;
					end
					seen_nx = seen_q + 4'd1;
					done    = (seen_nx >= frame_len_q);
					has_result          = 1'b1;
					result.kind         = sfr_pkg::KIND_PAYLOAD;
					result.service_id   = service_q;
					result.byte_index   = idx;
					result.payload_byte = b;
					result.last         = done;
					if (done) begin
						phase_nx = sfr_pkg::PH_HUNT;
						if (is_button) begin
							result.button_changed = pending_nx ^ buttons_q;
							buttons_nx            = pending_nx;
						end
					end
				end
				default: begin
					phase_nx = sfr_pkg::PH_HUNT;
					if (!hdr_ok) begin
						has_result  = 1'b1;
						result.kind = sfr_pkg::KIND_BAD_HEADER;
					end else if (hdr_len == 4'd0) begin
						has_result  = 1'b1;
						result.kind = sfr_pkg::KIND_RESET;
						result.last = 1'b1;
					end else begin
						frame_len_nx = hdr_len;
						seen_nx      = 4'd0;
						phase_nx     = sfr_pkg::PH_SERVICE;
					end
				end
			endcase
		end
		result.buttons_now = buttons_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= sfr_pkg::PH_HUNT;
			frame_len_q <= '0;
			seen_q      <= '0;
			service_q   <= '0;
			pending_q   <= '0;
			buttons_q   <= '0;
		end else if (step) begin
			phase_q     <= phase_nx;
			frame_len_q <= frame_len_nx;
			seen_q      <= seen_nx;
			service_q   <= service_nx;
			pending_q   <= pending_nx;
			buttons_q   <= buttons_nx;
		end
	end

	// A timeout always drops the receiver back to header hunting.
	a_timeout_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		step && item_s1.action == sfr_pkg::ACT_TIMEOUT |=> phase_q == sfr_pkg::PH_HUNT)
		else $error("timeout did not return to hunting");

	// The button state moves only on the completing byte of a frame.
	a_buttons_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(step && done) |=> $stable(buttons_q))
		else $error("button state changed outside frame completion");

	// A changed-bit mask is only reported on a completing payload byte.
	a_changed_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		has_result && result.button_changed != 8'd0 |->
			result.last && result.kind == sfr_pkg::KIND_PAYLOAD)
		else $error("button change reported off frame completion");

endmodule

### hw/rtl/sfr_out_stage.sv
// Result register: one slot, refilled in the same cycle it is drained.
module sfr_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  sfr_pkg::result_t  result,
	output logic              can_load,
	output logic              out_valid,
	input  logic              out_ready,
	output sfr_pkg::result_t  result_q
);

	logic valid_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			result_q <= result;
		end
	end

endmodule

### hw/rtl/switch_frame_receiver.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    action, rx_byte
// out       out_valid / out_ready  kind, service_id, byte_index, payload_byte, last,
//                                  button_changed, buttons_now
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per clock is sustained while the result register has room; an
// accepted item is held in the input register and its result then in the result register.
// An item leaves the input register only when the result register has room, even
// if it makes no result; a stalled output thus holds it and in_ready falls.
// arst_n clears the frame state, the button state and both valid flags; the
// configuration returns to a length limit of 15 and button service id 0.
module switch_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] rx_byte,

	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] kind,
	output logic [7:0] service_id,
	output logic [3:0] byte_index,
	output logic [7:0] payload_byte,
	output logic       last,
	output logic [7:0] button_changed,
	output logic [7:0] buttons_now,

	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	sfr_pkg::cfg_t    cfg_q;
	sfr_pkg::item_t   item_in;
	sfr_pkg::item_t   item_s1;
	sfr_pkg::result_t result;
	sfr_pkg::result_t result_q;
	logic             valid_s1;
	logic             advance;
	logic             can_load;
	logic             has_result;

	// Configuration is to be written only while the receiver is idle; the block itself
	// does not enforce this. cfg_ready is tied high, so writes are always taken at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_len   <= sfr_pkg::MAX_LEN_RESET;
			cfg_q.button_id <= sfr_pkg::BUTTON_ID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfr_pkg::CFG_MAX_LEN:   cfg_q.max_len   <= cfg_data[3:0];
				sfr_pkg::CFG_BUTTON_ID: cfg_q.button_id <= cfg_data;
				default: ;
			endcase
		end
	end

	assign item_in.action  = action;
	assign item_in.rx_byte = rx_byte;

	// The held item moves on when the result register can take whatever it makes.
	assign advance = valid_s1 && can_load;

	sfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	sfr_deframer u_deframer (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.step       (advance),
		.item_s1    (item_s1),
		.has_result (has_result),
		.result     (result)
	);

	sfr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && has_result),
		.result    (result),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_q  (result_q)
	);

	assign kind           = result_q.kind;
	assign service_id     = result_q.service_id;
	assign byte_index     = result_q.byte_index;
	assign payload_byte   = result_q.payload_byte;
	assign last           = result_q.last;
	assign button_changed = result_q.button_changed;
	assign buttons_now    = result_q.buttons_now;

endmodule
